FILE: src/event_fifo_and_timed_slot_scheduler_unit_assert.svh
// Assertion macros for the scheduler RTL.
`ifndef EVENT_FIFO_AND_TIMED_SLOT_SCHEDULER_UNIT_ASSERT_SVH
`define EVENT_FIFO_AND_TIMED_SLOT_SCHEDULER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define EFTS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("efts check failed");
`define EFTS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("efts check failed");
`else
`define EFTS_ASSERT(label, prop)
`define EFTS_ASSERT_ALWAYS(label, prop)
`endif
`endif

FILE: src/efts_pkg.sv
`default_nettype none
package efts_pkg;

  localparam int QUEUE_SLOTS_DEF = 16;
  localparam int MAX_EVENTS      = 31;
  localparam int EW              = 5;

  localparam logic [1:0] MODE_SUBMIT  = 2'd0;
  localparam logic [1:0] MODE_PROCESS = 2'd1;
  localparam logic [1:0] MODE_PURGE   = 2'd2;

  typedef enum logic [2:0] {
    KIND_ACCEPTED  = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_NULL      = 3'd2,
    KIND_EVENT     = 3'd3,
    KIND_PROC_DONE = 3'd4,
    KIND_PURGE_DONE = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUBMIT_SCAN,
    ST_PROC_FIFO,
    ST_PROC_SLOT,
    ST_PURGE_FIFO,
    ST_PURGE_SLOT,
    ST_FINAL
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] src;
    logic [15:0] tgt;
    logic [3:0]  code;
    logic [31:0] arg;
    logic        last;
  } result_t;

  typedef struct packed {
    logic names;
    logic busy;
    logic due_ok;
  } cmp_t;

endpackage
`default_nettype wire

FILE: src/event_fifo_and_timed_slot_scheduler_unit.sv
// Event FIFO and timed slot scheduler.
// Input channel (in_valid/in_ready) takes one request beat: submit, process
// or purge. Output channel (out_valid/out_ready) returns result beats; the
// final beat of each request has last_result set. Mode three is taken and
// ignored with no result.
// in_ready is high only while the sequencer is idle; one request is worked
// on at a time by a small sequencer around one shared compare unit.
// An immediate or rejected submit goes straight to its result beat; a delayed
// submit walks the slot table one slot per cycle up to the first free slot.
// Process emits one FIFO entry per cycle while the output register is free,
// then walks the slot table one slot per cycle, holding on a due slot while
// the output register is busy, then sends the done beat. Purge walks the FIFO
// once and the slot table once.
// A stalled receiver holds the output register; the sequencer waits before
// each new result beat until the register frees up.
// Reset empties the FIFO and frees every slot at once (due ticks cleared).
`default_nettype none
module event_fifo_and_timed_slot_scheduler_unit #(
  parameter int QUEUE_SLOTS = efts_pkg::QUEUE_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         mode,
  input  wire logic [15:0]        source_id,
  input  wire logic [15:0]        target_id,
  input  wire logic [3:0]         event_code,
  input  wire logic [31:0]        event_argument,
  input  wire logic signed [31:0] delay_ticks,
  input  wire logic [31:0]        current_tick,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              result_kind,
  output logic [15:0]             out_source,
  output logic [15:0]             out_target,
  output logic [3:0]              out_event_code,
  output logic [31:0]             out_argument,
  output logic                    last_result
);
  import efts_pkg::*;

  localparam int IW = $clog2(QUEUE_SLOTS);
  localparam int CW = $clog2(QUEUE_SLOTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_SLOTS - 1);
  localparam logic [CW-1:0] SLOTS_C  = CW'(QUEUE_SLOTS);
  localparam logic [EW-1:0] MAX_C    = EW'(MAX_EVENTS);

  // Storage
  logic [31:0] fifo_obj  [QUEUE_SLOTS];
  logic [35:0] fifo_pay  [QUEUE_SLOTS];
  logic [31:0] slot_obj  [QUEUE_SLOTS];
  logic [35:0] slot_pay  [QUEUE_SLOTS];
  logic [31:0] slot_due  [QUEUE_SLOTS];
  logic [IW-1:0] rp, wp, prd, pwr;
  logic [CW-1:0] in_use, scan;
  logic [EW-1:0] n_emit;

  // Latched request
  logic [15:0] src_q, tgt_q;
  logic [3:0]  code_q;
  logic [31:0] arg_q, due_q, tick_q;
  kind_t       fin_kind, fin_kind_next;

  state_t state, state_next;

  // Sequencer strobes
  logic    fifo_push, slot_fill, slot_free, fifo_pop, purge_keep, purge_step;
  logic    out_load, out_free;
  result_t res;
  cmp_t    cmp;

  logic [IW-1:0] sidx, fidx;
  logic [31:0]   due_in;
  logic          accept;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign due_in   = current_tick + delay_ticks;
  assign sidx     = scan[IW-1:0];
  assign fidx     = (state == ST_PURGE_FIFO) ? prd : rp;

  // Shared compare unit: object match for purge, free and due tests for slots
  efts_cmp u_cmp (
    .objs ((state == ST_PURGE_FIFO) ? fifo_obj[fidx] : slot_obj[sidx]),
    .obj  (src_q),
    .due  (slot_due[sidx]),
    .tick (tick_q),
    .res  (cmp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    fin_kind_next = fin_kind;
    fifo_push     = 1'b0;
    slot_fill     = 1'b0;
    slot_free     = 1'b0;
    fifo_pop      = 1'b0;
    purge_keep    = 1'b0;
    purge_step    = 1'b0;
    out_load      = 1'b0;
    res           = '{kind: fin_kind, src: '0, tgt: '0, code: '0, arg: '0, last: 1'b1};
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority case (mode)
            MODE_SUBMIT: begin
              state_next = ST_FINAL;
              priority if (source_id == 16'd0 || target_id == 16'd0) begin
                fin_kind_next = KIND_NULL;
              end else if (delay_ticks == 32'sd0) begin
                if (ring_next(wp) == rp) begin
                  fin_kind_next = KIND_FULL;
                end else begin
                  fin_kind_next = KIND_ACCEPTED;
                  fifo_push     = 1'b1;
                end
              end else if (in_use >= SLOTS_C) begin
                fin_kind_next = KIND_FULL;
              end else if (due_in == 32'd0) begin
                fin_kind_next = KIND_NULL;
              end else begin
                fin_kind_next = KIND_FULL;
                state_next    = ST_SUBMIT_SCAN;
              end
            end
            MODE_PROCESS: begin
              fin_kind_next = KIND_PROC_DONE;
              state_next    = ST_PROC_FIFO;
            end
            MODE_PURGE: begin
              fin_kind_next = KIND_PURGE_DONE;
              state_next    = ST_PURGE_FIFO;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SUBMIT_SCAN: begin
        if (scan == SLOTS_C) begin
          state_next = ST_FINAL;
        end else if (!cmp.busy) begin
          slot_fill     = 1'b1;
          fin_kind_next = KIND_ACCEPTED;
          state_next    = ST_FINAL;
        end
      end
      ST_PROC_FIFO: begin
        res = '{kind: KIND_EVENT, src: fifo_obj[fidx][31:16], tgt: fifo_obj[fidx][15:0],
                code: fifo_pay[fidx][35:32], arg: fifo_pay[fidx][31:0], last: 1'b0};
        if (rp == wp || n_emit == MAX_C) begin
          state_next = ST_PROC_SLOT;
        end else if (out_free) begin
          out_load = 1'b1;
          fifo_pop = 1'b1;
        end
      end
      ST_PROC_SLOT: begin
        res = '{kind: KIND_EVENT, src: slot_obj[sidx][31:16], tgt: slot_obj[sidx][15:0],
                code: slot_pay[sidx][35:32], arg: slot_pay[sidx][31:0], last: 1'b0};
        if (scan == SLOTS_C || n_emit == MAX_C) begin
          state_next = ST_FINAL;
        end else if (cmp.due_ok) begin
          if (out_free) begin
            out_load  = 1'b1;
            slot_free = 1'b1;
          end
        end
      end
      ST_PURGE_FIFO: begin
        if (prd == wp) begin
          state_next = ST_PURGE_SLOT;
        end else begin
          purge_step = 1'b1;
          purge_keep = !cmp.names;
        end
      end
      ST_PURGE_SLOT: begin
        if (scan == SLOTS_C) begin
          state_next = ST_FINAL;
        end else begin
          slot_free = cmp.busy && cmp.names;
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers: pointers, counters, due ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      rp       <= '0;
      wp       <= '0;
      prd      <= '0;
      pwr      <= '0;
      in_use   <= '0;
      scan     <= '0;
      n_emit   <= '0;
      fin_kind <= KIND_ACCEPTED;
      for (int i = 0; i < QUEUE_SLOTS; i++) begin
        slot_due[i] <= '0;
      end
    end else begin
      fin_kind <= fin_kind_next;
      if (accept) begin
        scan   <= '0;
        n_emit <= '0;
        prd    <= rp;
        pwr    <= rp;
      end
      if (fifo_push) begin
        wp <= ring_next(wp);
      end
      if (fifo_pop) begin
        rp     <= ring_next(rp);
        n_emit <= n_emit + 1'b1;
      end
      // advance the slot walk on every slot-table state that is not stalled
      if (state == ST_SUBMIT_SCAN || state == ST_PURGE_SLOT ||
          (state == ST_PROC_SLOT && !(cmp.due_ok && !out_free))) begin
        scan <= scan + 1'b1;
      end
      if (state == ST_PROC_FIFO && state_next == ST_PROC_SLOT) begin
        scan <= '0;
      end
      if (state == ST_PURGE_FIFO && state_next == ST_PURGE_SLOT) begin
        wp   <= pwr;
        scan <= '0;
      end
      if (purge_step) begin
        prd <= ring_next(prd);
        if (purge_keep) begin
          pwr <= ring_next(pwr);
        end
      end
      if (slot_fill) begin
        slot_due[sidx] <= due_q;
        in_use         <= in_use + 1'b1;
      end
      if (slot_free) begin
        slot_due[sidx] <= '0;
        if (in_use != '0) begin
          in_use <= in_use - 1'b1;
        end
        if (state == ST_PROC_SLOT) begin
          n_emit <= n_emit + 1'b1;
        end
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      src_q  <= source_id;
      tgt_q  <= target_id;
      code_q <= event_code;
      arg_q  <= event_argument;
      due_q  <= due_in;
      tick_q <= current_tick;
    end
    if (fifo_push) begin
      fifo_obj[wp] <= {source_id, target_id};
      fifo_pay[wp] <= {event_code, event_argument};
    end
    if (purge_keep) begin
      fifo_obj[pwr] <= fifo_obj[prd];
      fifo_pay[pwr] <= fifo_pay[prd];
    end
    if (slot_fill) begin
      slot_obj[sidx] <= {src_q, tgt_q};
      slot_pay[sidx] <= {code_q, arg_q};
    end
  end

  efts_outreg u_out (
    .clk            (clk),
    .rst            (rst),
    .load           (out_load),
    .d              (res),
    .free           (out_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .out_source     (out_source),
    .out_target     (out_target),
    .out_event_code (out_event_code),
    .out_argument   (out_argument),
    .last_result    (last_result)
  );

`include "event_fifo_and_timed_slot_scheduler_unit_assert.svh"

  `EFTS_ASSERT(a_in_use_bound, in_use <= SLOTS_C)
  `EFTS_ASSERT(a_emit_bound, n_emit <= MAX_C)
  `EFTS_ASSERT(a_idle_after_last, $rose(in_ready) |-> $past(out_load && res.last))

endmodule
`default_nettype wire

FILE: src/efts_cmp.sv
`default_nettype none
module efts_cmp (
  input  wire logic [31:0] objs,
  input  wire logic [15:0] obj,
  input  wire logic [31:0] due,
  input  wire logic [31:0] tick,
  output efts_pkg::cmp_t   res
);
  import efts_pkg::*;

  always_comb begin
    res.names  = (objs[31:16] == obj) || (objs[15:0] == obj);
    res.busy   = (due != 32'd0);
    res.due_ok = (due != 32'd0) && (tick >= due);
  end
endmodule
`default_nettype wire

FILE: src/efts_outreg.sv
`default_nettype none
module efts_outreg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  efts_pkg::result_t      d,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             result_kind,
  output logic [15:0]            out_source,
  output logic [15:0]            out_target,
  output logic [3:0]             out_event_code,
  output logic [31:0]            out_argument,
  output logic                   last_result
);
  import efts_pkg::*;

  result_t q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

  assign free           = !out_valid || out_ready;
  assign result_kind    = q.kind;
  assign out_source     = q.src;
  assign out_target     = q.tgt;
  assign out_event_code = q.code;
  assign out_argument   = q.arg;
  assign last_result    = q.last;
endmodule
`default_nettype wire

FILE: tb/tb_event_fifo_and_timed_slot_scheduler_unit.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_event_fifo_and_timed_slot_scheduler_unit;
  import efts_pkg::*;

  localparam int SLOTS = QUEUE_SLOTS_DEF;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int NO_EXPECT = -1;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] mode;
  logic [15:0] source_id, target_id;
  logic [3:0] event_code;
  logic [31:0] event_argument, current_tick;
  logic signed [31:0] delay_ticks;
  logic [2:0] result_kind;
  logic [15:0] out_source, out_target;
  logic [3:0] out_event_code;
  logic [31:0] out_argument;
  logic last_result;

  event_fifo_and_timed_slot_scheduler_unit DUT (.*);

  // One request beat as the sender sees it.
  typedef struct {
    logic [1:0]  md;
    logic [15:0] src;
    logic [15:0] tgt;
    logic [3:0]  code;
    logic [31:0] arg;
    logic [31:0] dly;
    logic [31:0] tick;
  } request_t;

  // One stored event.
  typedef struct packed {
    logic [15:0] src;
    logic [15:0] tgt;
    logic [3:0]  code;
    logic [31:0] arg;
  } sched_event_t;

  // Shadow copy of the scheduler state.
  sched_event_t ring_mem [SLOTS];
  int unsigned  ring_rd, ring_wr;
  sched_event_t slot_mem [SLOTS];
  logic [31:0]  slot_due [SLOTS];
  int unsigned  slot_count;

  result_t pending_results[$];
  int      errors;
  int      send_idle_pct, recv_idle_pct;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Hard stop if the block hangs.
  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned ring_step(int unsigned p);
    return (p + 1 >= SLOTS) ? 0 : p + 1;
  endfunction

  function automatic result_t make_result(kind_t k, sched_event_t e, logic lst);
    result_t r;
    r.kind = k;
    r.src  = e.src;
    r.tgt  = e.tgt;
    r.code = e.code;
    r.arg  = e.arg;
    r.last = lst;
    return r;
  endfunction

  function automatic kind_t schedule_submit(request_t q);
    sched_event_t e;
    logic [31:0] due;
    e = '{q.src, q.tgt, q.code, q.arg};
    if (q.src == 0 || q.tgt == 0) return KIND_NULL;
    if (q.dly == 0) begin
      if (ring_step(ring_wr) == ring_rd) return KIND_FULL;
      ring_mem[ring_wr] = e;
      ring_wr = ring_step(ring_wr);
      return KIND_ACCEPTED;
    end
    if (slot_count >= SLOTS) return KIND_FULL;
    due = q.tick + q.dly;
    if (due == 0) return KIND_NULL;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_due[i] == 0) begin
        slot_mem[i] = e;
        slot_due[i] = due;
        slot_count++;
        return KIND_ACCEPTED;
      end
    end
    return KIND_FULL;
  endfunction

  // Advance the shadow state by one request and queue what it should return.
  function automatic void predict_results(request_t q);
    sched_event_t none, keep;
    int n;
    int unsigned rd, wr;
    none = '0;
    n = 0;
    case (q.md)
      MODE_SUBMIT: pending_results.push_back(make_result(schedule_submit(q), none, 1'b1));
      MODE_PROCESS: begin
        while (ring_rd != ring_wr && n < MAX_EVENTS) begin
          pending_results.push_back(make_result(KIND_EVENT, ring_mem[ring_rd], 1'b0));
          ring_rd = ring_step(ring_rd);
          n++;
        end
        for (int i = 0; i < SLOTS && n < MAX_EVENTS; i++) begin
          if (slot_due[i] != 0 && q.tick >= slot_due[i]) begin
            pending_results.push_back(make_result(KIND_EVENT, slot_mem[i], 1'b0));
            slot_due[i] = 0;
            if (slot_count > 0) slot_count--;
            n++;
          end
        end
        pending_results.push_back(make_result(KIND_PROC_DONE, none, 1'b1));
      end
      MODE_PURGE: begin
        rd = ring_rd;
        wr = ring_rd;
        while (rd != ring_wr) begin
          keep = ring_mem[rd];
          if (keep.src != q.src && keep.tgt != q.src) begin
            ring_mem[wr] = keep;
            wr = ring_step(wr);
          end
          rd = ring_step(rd);
        end
        ring_wr = wr;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_due[i] != 0 && (slot_mem[i].src == q.src || slot_mem[i].tgt == q.src))
          begin
            slot_due[i] = 0;
            if (slot_count > 0) slot_count--;
          end
        end
        pending_results.push_back(make_result(KIND_PURGE_DONE, none, 1'b1));
      end
      default: ;
    endcase
  endfunction

  // Drive one request beat, hold it until accepted, then predict.
  // Valid drops only while the sender idles; back to back beats keep it high.
  task automatic send_request(request_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    mode           <= q.md;
    source_id      <= q.src;
    target_id      <= q.tgt;
    event_code     <= q.code;
    event_argument <= q.arg;
    delay_ticks    <= q.dly;
    current_tick   <= q.tick;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_results(q);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * SLOTS + 8) @(posedge clk);
  endtask

  // Receiver: stall at random, check each accepted beat against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected beat kind=%0d", $time, result_kind);
          errors++;
        end else begin
          result_t w;
          w = pending_results.pop_front();
          if (result_kind !== w.kind || out_source !== w.src || out_target !== w.tgt ||
              out_event_code !== w.code || out_argument !== w.arg ||
              last_result !== w.last) begin
            $display("%0t: mismatch expected kind=%0d src=%h tgt=%h code=%h arg=%h last=%b",
                     $time, w.kind, w.src, w.tgt, w.code, w.arg, w.last);
            $display("%0t:          actual   kind=%0d src=%h tgt=%h code=%h arg=%h last=%b",
                     $time, result_kind, out_source, out_target, out_event_code,
                     out_argument, last_result);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Small id pool so purges and collisions actually hit stored events.
  function automatic logic [15:0] pick_id();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic request_t random_request(logic [31:0] tick);
    request_t q;
    int sel;
    sel = $urandom_range(99);
    q.md   = sel < 60 ? MODE_SUBMIT : sel < 85 ? MODE_PROCESS : sel < 97 ? MODE_PURGE
                                                                       : MODE_SPARE;
    q.src  = pick_id();
    q.tgt  = pick_id();
    q.code = 4'($urandom_range(9));
    q.arg  = $urandom;
    case ($urandom_range(7))
      0, 1, 2: q.dly = 0;
      3:       q.dly = $urandom;
      4:       q.dly = -tick;
      5:       q.dly = -32'($urandom_range(1, 20));
      default: q.dly = $urandom_range(1, 40);
    endcase
    q.tick = ($urandom_range(19) == 0) ? $urandom : tick + $urandom_range(0, 30);
    return q;
  endfunction

  // Directed rows: mode, src, tgt, code, arg, delay, tick.
  localparam int DIRECTED_ROWS = 22;
  request_t directed_rows [DIRECTED_ROWS];
  // Typed-in kind of the single result of a row, or NO_EXPECT for the predictor.
  int       directed_expect [DIRECTED_ROWS];

  initial begin
    request_t q;
    logic [31:0] tick;
    sched_event_t blank;
    errors = 0;
    send_idle_pct = 28;
    recv_idle_pct = 71;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_SUBMIT;
    source_id = '0;
    target_id = '0;
    event_code = '0;
    event_argument = '0;
    delay_ticks = '0;
    current_tick = '0;
    ring_rd = 0;
    ring_wr = 0;
    slot_count = 0;
    blank = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_due[i] = '0;
      ring_mem[i] = '0;
      slot_mem[i] = '0;
    end

    directed_rows = '{
      '{MODE_PROCESS, 16'h0, 16'h0, 4'h0, 32'h0, 32'h0, 32'h0},        // empty process
      '{MODE_SUBMIT, 16'h0, 16'h1, 4'h1, 32'h1, 32'h0, 32'h0},         // null source
      '{MODE_SUBMIT, 16'h1, 16'h0, 4'h1, 32'h1, 32'h5, 32'h0},         // null target
      '{MODE_SUBMIT, 16'hFFFF, 16'hFFFF, 4'h9, 32'hFFFFFFFF, 32'h0, 32'h0},
      '{MODE_SUBMIT, 16'h1, 16'h2, 4'h0, 32'h0, 32'h0, 32'h0},
      '{MODE_SUBMIT, 16'h2, 16'h3, 4'h5, 32'hA5A5A5A5, 32'd10, 32'd100},
      '{MODE_SUBMIT, 16'h3, 16'h4, 4'h6, 32'h5A5A5A5A, 32'h7FFFFFFF, 32'd1},
      '{MODE_SUBMIT, 16'h4, 16'h5, 4'h7, 32'h1234, 32'h80000000, 32'hFFFFFFFF},
      '{MODE_SUBMIT, 16'h5, 16'h6, 4'h8, 32'h1, 32'hFFFFFFFF, 32'd1},  // due wraps to zero
      '{MODE_SUBMIT, 16'h5, 16'h6, 4'h8, 32'h2, 32'hFFFFFFF6, 32'd50}, // negative delay
      '{MODE_SPARE, 16'h1, 16'h1, 4'h1, 32'h1, 32'h0, 32'h0},          // ignored mode
      '{MODE_PROCESS, 16'h0, 16'h0, 4'h0, 32'h0, 32'h0, 32'd105},
      '{MODE_PURGE, 16'h0, 16'h0, 4'h0, 32'h0, 32'h0, 32'h0},          // purge object zero
      '{MODE_SUBMIT, 16'h7, 16'h8, 4'h2, 32'h77, 32'h0, 32'h0},
      '{MODE_SUBMIT, 16'h9, 16'h7, 4'h3, 32'h88, 32'h0, 32'h0},
      '{MODE_SUBMIT, 16'hA, 16'hB, 4'h4, 32'h99, 32'h0, 32'h0},
      '{MODE_SUBMIT, 16'h7, 16'hC, 4'h1, 32'h66, 32'd3, 32'd200},
      '{MODE_PURGE, 16'h7, 16'h0, 4'h0, 32'h0, 32'h0, 32'h0},          // purge keeps order
      '{MODE_PROCESS, 16'h0, 16'h0, 4'h0, 32'h0, 32'h0, 32'hFFFFFFFF},
      '{MODE_PROCESS, 16'h0, 16'h0, 4'h0, 32'h0, 32'h0, 32'hFFFFFFFF},
      '{MODE_PURGE, 16'hFFFF, 16'h0, 4'h0, 32'h0, 32'h0, 32'h0},
      '{MODE_PROCESS, 16'h0, 16'h0, 4'h0, 32'h0, 32'h0, 32'h0}
    };

    directed_expect = '{
      KIND_PROC_DONE, KIND_NULL, KIND_NULL, KIND_ACCEPTED, NO_EXPECT,
      NO_EXPECT, NO_EXPECT, NO_EXPECT, KIND_NULL, NO_EXPECT,
      NO_EXPECT, NO_EXPECT, KIND_PURGE_DONE, NO_EXPECT, NO_EXPECT,
      NO_EXPECT, NO_EXPECT, KIND_PURGE_DONE, NO_EXPECT, NO_EXPECT,
      KIND_PURGE_DONE, NO_EXPECT
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_request(directed_rows[i]);
      // Rows with a typed-in answer are checked against it, not the predictor.
      if (directed_expect[i] != NO_EXPECT) begin
        void'(pending_results.pop_back());
        pending_results.push_back(make_result(kind_t'(directed_expect[i]), blank, 1'b1));
      end
    end

    // Fill both stores past capacity to hit the full drops.
    for (int i = 0; i < SLOTS + 1; i++)
      send_request('{MODE_SUBMIT, 16'(i + 1), 16'h2, 4'(i % 10), $urandom, 32'h0, 32'h0});
    for (int i = 0; i < SLOTS + 1; i++)
      send_request('{MODE_SUBMIT, 16'h3, 16'(i + 1), 4'(i % 10), $urandom, 32'd5, 32'd10});
    // Pause until the block has answered everything, then drain both stores.
    drain_results();
    send_request('{MODE_PROCESS, 16'h0, 16'h0, 4'h0, 32'h0, 32'h0, 32'd20});

    tick = 32'd1000;
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 71;
        recv_idle_pct = 28;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < 110; n++) begin
        q = random_request(tick);
        tick = q.tick;
        send_request(q);
        if (n == 55 && phase == 0) drain_results();
      end
    end

    drain_results();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
